// File: hw/rtl/line_quad_intersect_test_core_assert.svh
// Assertion macros shared by the checker of line_quad_intersect_test_core.
// No dependencies; include by bare file name.
`ifndef LINE_QUAD_INTERSECT_TEST_CORE_ASSERT_SVH
`define LINE_QUAD_INTERSECT_TEST_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LQIT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lqit assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LQIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lqit assertion failed");

`endif

// File: hw/rtl/lqit_pkg.sv
// Package for the line/quadrilateral intersection test core.
// Holds register codes, bus widths and pipeline constants; no dependencies.
package lqit_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int APB_DATA_W     = 64;
    localparam int APB_ADDR_W     = 5;
    localparam int REG_ADDR_LSB   = 3;   // registers sit on 8-byte boundaries
    localparam int DP_STAGES      = 4;   // register stages inside lqit_datapath
    localparam int OUT_W          = 8;   // hit padded to one byte

    typedef enum logic [1:0] {
        REG_VERTEX_A = 2'd0,
        REG_VERTEX_B = 2'd1,
        REG_VERTEX_C = 2'd2,
        REG_VERTEX_D = 2'd3
    } reg_idx_t;

endpackage

// File: hw/rtl/lqit_datapath.sv
// Arithmetic pipeline of the intersection test: differences, cross products,
// dot products and the final sign decision. Depends on lqit_pkg.
module lqit_datapath
    import lqit_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [3*COORD_BITS-1:0]   pt_start,   // x, y, z from the low bits up
    input  logic [3*COORD_BITS-1:0]   pt_end,
    input  logic [3*COORD_BITS-1:0]   vtx_a,
    input  logic [3*COORD_BITS-1:0]   vtx_b,
    input  logic [3*COORD_BITS-1:0]   vtx_c,
    input  logic [3*COORD_BITS-1:0]   vtx_d,
    output logic                      hit          // valid with the last stage
);

    localparam int DW = COORD_BITS + 1;        // coordinate difference
    localparam int PW = 2 * DW;                // first-level product
    localparam int XW = PW + 1;                // cross product component
    localparam int QW = DW + XW;               // second-level product
    localparam int SW = QW + 2;                // sum of three products

    localparam int unsigned NXT [3] = '{1, 2, 0};
    localparam int unsigned PRV [3] = '{2, 0, 1};

    logic signed [COORD_BITS-1:0] p [3];
    logic signed [COORD_BITS-1:0] q [3];
    logic signed [COORD_BITS-1:0] a [3];
    logic signed [COORD_BITS-1:0] b [3];
    logic signed [COORD_BITS-1:0] c [3];
    logic signed [COORD_BITS-1:0] d [3];

    // stage 1: differences
    logic signed [DW-1:0] pq_reg [3];
    logic signed [DW-1:0] pa_reg [3];
    logic signed [DW-1:0] pb_reg [3];
    logic signed [DW-1:0] pc_reg [3];
    logic signed [DW-1:0] pd_reg [3];
    // stage 2: cross product terms
    logic signed [PW-1:0] ml_reg [3];
    logic signed [PW-1:0] mr_reg [3];
    logic signed [PW-1:0] bl_reg [3];
    logic signed [PW-1:0] br_reg [3];
    logic signed [PW-1:0] al_reg [3];
    logic signed [PW-1:0] ar_reg [3];
    logic signed [DW-1:0] pa2_reg [3];
    logic signed [DW-1:0] pb2_reg [3];
    logic signed [DW-1:0] pd2_reg [3];
    // stage 3: cross products
    logic signed [XW-1:0] m_reg [3];
    logic signed [XW-1:0] xb_reg [3];
    logic signed [XW-1:0] xa_reg [3];
    logic signed [DW-1:0] pa3_reg [3];
    logic signed [DW-1:0] pb3_reg [3];
    logic signed [DW-1:0] pd3_reg [3];
    // stage 4: dot product terms
    logic signed [QW-1:0] pam_reg [3];
    logic signed [QW-1:0] pbm_reg [3];
    logic signed [QW-1:0] pdm_reg [3];
    logic signed [QW-1:0] tb_reg [3];
    logic signed [QW-1:0] ta_reg [3];

    logic signed [SW-1:0] v_sum;
    logic signed [SW-1:0] pbm_sum;
    logic signed [SW-1:0] pdm_sum;
    logic signed [SW-1:0] tb_sum;
    logic signed [SW-1:0] ta_sum;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            p[k] = pt_start[k*COORD_BITS +: COORD_BITS];
            q[k] = pt_end[k*COORD_BITS +: COORD_BITS];
            a[k] = vtx_a[k*COORD_BITS +: COORD_BITS];
            b[k] = vtx_b[k*COORD_BITS +: COORD_BITS];
            c[k] = vtx_c[k*COORD_BITS +: COORD_BITS];
            d[k] = vtx_d[k*COORD_BITS +: COORD_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                // stage 1
                pq_reg[k] <= DW'(q[k]) - DW'(p[k]);
                pa_reg[k] <= DW'(a[k]) - DW'(p[k]);
                pb_reg[k] <= DW'(b[k]) - DW'(p[k]);
                pc_reg[k] <= DW'(c[k]) - DW'(p[k]);
                pd_reg[k] <= DW'(d[k]) - DW'(p[k]);
                // stage 2: m = pc x pq, xb = pq x pb, xa = pq x pa
                ml_reg[k]  <= pc_reg[NXT[k]] * pq_reg[PRV[k]];
                mr_reg[k]  <= pc_reg[PRV[k]] * pq_reg[NXT[k]];
                bl_reg[k]  <= pq_reg[NXT[k]] * pb_reg[PRV[k]];
                br_reg[k]  <= pq_reg[PRV[k]] * pb_reg[NXT[k]];
                al_reg[k]  <= pq_reg[NXT[k]] * pa_reg[PRV[k]];
                ar_reg[k]  <= pq_reg[PRV[k]] * pa_reg[NXT[k]];
                pa2_reg[k] <= pa_reg[k];
                pb2_reg[k] <= pb_reg[k];
                pd2_reg[k] <= pd_reg[k];
                // stage 3
                m_reg[k]   <= XW'(ml_reg[k]) - XW'(mr_reg[k]);
                xb_reg[k]  <= XW'(bl_reg[k]) - XW'(br_reg[k]);
                xa_reg[k]  <= XW'(al_reg[k]) - XW'(ar_reg[k]);
                pa3_reg[k] <= pa2_reg[k];
                pb3_reg[k] <= pb2_reg[k];
                pd3_reg[k] <= pd2_reg[k];
                // stage 4
                pam_reg[k] <= pa3_reg[k] * m_reg[k];
                pbm_reg[k] <= pb3_reg[k] * m_reg[k];
                pdm_reg[k] <= pd3_reg[k] * m_reg[k];
                tb_reg[k]  <= xb_reg[k] * pa3_reg[k];
                ta_reg[k]  <= xa_reg[k] * pd3_reg[k];
            end
        end
    end

    always_comb
    begin
        v_sum   = SW'(pam_reg[0]) + SW'(pam_reg[1]) + SW'(pam_reg[2]);
        pbm_sum = SW'(pbm_reg[0]) + SW'(pbm_reg[1]) + SW'(pbm_reg[2]);
        pdm_sum = SW'(pdm_reg[0]) + SW'(pdm_reg[1]) + SW'(pdm_reg[2]);
        tb_sum  = SW'(tb_reg[0]) + SW'(tb_reg[1]) + SW'(tb_reg[2]);
        ta_sum  = SW'(ta_reg[0]) + SW'(ta_reg[1]) + SW'(ta_reg[2]);
        if (!v_sum[SW-1])
        begin
            // triangle abc: pb.m must not be positive, xb.pa must not be negative
            hit = (pbm_sum[SW-1] || (pbm_sum == '0)) && !tb_sum[SW-1];
        end
        else
        begin
            // triangle dac
            hit = !pdm_sum[SW-1] && !ta_sum[SW-1];
        end
    end

endmodule

// File: hw/rtl/line_quad_intersect_test_core.sv
// Line/quadrilateral intersection test core: for each item (two points p, q)
// report whether the infinite line through p and q passes through the
// quadrilateral abcd held in four configuration registers. A zero sign test
// counts as a hit, so p == q always reports a hit. Arithmetic is exact
// integer math, no rounding. Rate: one item per clock cycle while the output
// register is not stalled. The first of the four register stages in
// lqit_datapath captures the item at the accepting edge; the other three
// stages and then the output register follow, and the result shows on
// m_tvalid from the output register. The whole pipeline moves
// as one: it advances whenever the output register is empty or being taken,
// so s_tready follows m_tready combinationally and a stall holds every stage
// in place. Configuration (64-bit APB, vertices at byte addresses 0, 8, 16,
// 24; only paddr[4:3] are decoded) must be written while no item is in
// flight. Depends on lqit_pkg and lqit_datapath.
module line_quad_intersect_test_core
    import lqit_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z (COORD_BITS each), zero pad
    input  logic [((6*COORD_BITS+7)/8)*8-1:0]   s_tdata,
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // hit in bit 0, zero pad
    output logic [OUT_W-1:0]                    m_tdata,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [APB_ADDR_W-1:0]               paddr,
    input  logic [APB_DATA_W-1:0]               pwdata,
    output logic [APB_DATA_W-1:0]               prdata,
    output logic                                pready
);

    localparam int VW = 3 * COORD_BITS;   // packed vertex width

    logic [VW-1:0]        vtx_a_reg;
    logic [VW-1:0]        vtx_b_reg;
    logic [VW-1:0]        vtx_c_reg;
    logic [VW-1:0]        vtx_d_reg;
    reg_idx_t             reg_idx;
    logic                 cfg_wr;

    logic                 adv;            // whole pipeline steps forward
    logic [DP_STAGES-1:0] vld_reg;        // valid bit per datapath stage
    logic                 out_valid_reg;
    logic                 out_hit_reg;
    logic                 dp_hit;

    // ---------------------------------------------------------------
    // Configuration port: write on the access cycle, read any time.
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[REG_ADDR_LSB +: 2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx_a_reg <= '0;
            vtx_b_reg <= '0;
            vtx_c_reg <= '0;
            vtx_d_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_VERTEX_A: vtx_a_reg <= pwdata[VW-1:0];
                REG_VERTEX_B: vtx_b_reg <= pwdata[VW-1:0];
                REG_VERTEX_C: vtx_c_reg <= pwdata[VW-1:0];
                REG_VERTEX_D: vtx_d_reg <= pwdata[VW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_VERTEX_A: prdata = APB_DATA_W'(vtx_a_reg);
            REG_VERTEX_B: prdata = APB_DATA_W'(vtx_b_reg);
            REG_VERTEX_C: prdata = APB_DATA_W'(vtx_c_reg);
            REG_VERTEX_D: prdata = APB_DATA_W'(vtx_d_reg);
            default:      prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Flow control: advance when the output register is free or drains.
    // ---------------------------------------------------------------
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            // shift valid bits along with the datapath stages
            vld_reg       <= {vld_reg[DP_STAGES-2:0], s_tvalid};
            out_valid_reg <= vld_reg[DP_STAGES-1];
        end
    end

    // Hit flag carries no reset; only its valid bit matters.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_hit_reg <= dp_hit;
        end
    end

    lqit_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk      (clk),
        .en       (adv),
        .pt_start (s_tdata[VW-1:0]),
        .pt_end   (s_tdata[2*VW-1:VW]),
        .vtx_a    (vtx_a_reg),
        .vtx_b    (vtx_b_reg),
        .vtx_c    (vtx_c_reg),
        .vtx_d    (vtx_d_reg),
        .hit      (dp_hit)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W-1){1'b0}}, out_hit_reg};

endmodule

// File: hw/rtl/lqit_checker.sv
// Port-level checker for line_quad_intersect_test_core, bound to the top level.
// Depends on lqit_pkg and line_quad_intersect_test_core_assert.svh.
`include "line_quad_intersect_test_core_assert.svh"

module lqit_checker
    import lqit_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tready,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    input  logic             pready
);

    // a held result keeps its value until taken
    `LQIT_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // input side is open exactly when the output register can move
    `LQIT_ASSERT_NOW(a_ready_link, clk, rst_n, 1'b1, s_tready == (!m_tvalid || m_tready))
    // pad bits above hit stay clear
    `LQIT_ASSERT_NOW(a_out_pad, clk, rst_n, m_tvalid, m_tdata[OUT_W-1:1] == '0)
    // configuration port never waits
    `LQIT_ASSERT_NOW(a_pready, clk, rst_n, 1'b1, pready)

endmodule

bind line_quad_intersect_test_core lqit_checker u_lqit_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
